@@ rtl/core/wms_pkg.sv @@
// ----------------------------------------------------------------------------
// Wildcard multi-pattern scanner package
// Shared codes, sequencer states and the command and status words that pass
// between the controller and the datapath.
// ----------------------------------------------------------------------------
package wms_pkg;

  localparam logic [7:0] WILDCARD       = 8'h3F;
  localparam logic       MODE_LOAD      = 1'b0;
  localparam logic       MODE_SCAN      = 1'b1;
  localparam logic       REPORT_FOUND   = 1'b0;
  localparam logic       REPORT_SUMMARY = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_OFF_START,
    ST_RD,
    ST_CMP,
    ST_MATCH,
    ST_SUMMARY
  } state_t;

  typedef struct packed {
    logic take;
    logic pat_clear;
    logic pat_inc;
    logic skip_dec;
    logic advance;
    logic emit_match;
    logic emit_summary;
  } cmd_t;

  typedef struct packed {
    logic need_work;
    logic remain_ok;
    logic skip_zero;
    logic hit;
    logic last_pat;
    logic flushing;
    logic out_free;
  } status_t;

endpackage

@@ rtl/core/wms_ram.sv @@
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module wms_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/core/wms_ctrl.sv @@
// ----------------------------------------------------------------------------
// Wildcard multi-pattern scanner controller
// Sequences item intake, per-offset pattern tests, match reports and the
// end-of-region flush and summary.
// ----------------------------------------------------------------------------
module wms_ctrl
  import wms_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  input  status_t st,
  output cmd_t    cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid && st.need_work) begin
          state_next = ST_OFF_START;
        end
      end
      ST_OFF_START: begin
        if (!st.remain_ok) begin
          state_next = ST_SUMMARY;
        end else if (!st.skip_zero) begin
          state_next = st.flushing ? ST_OFF_START : ST_IDLE;
        end else begin
          state_next = ST_RD;
        end
      end
      ST_RD: begin
        state_next = ST_CMP;
      end
      ST_CMP: begin
        if (st.hit) begin
          state_next = ST_MATCH;
        end else if (st.last_pat) begin
          state_next = st.flushing ? ST_OFF_START : ST_IDLE;
        end else begin
          state_next = ST_RD;
        end
      end
      ST_MATCH: begin
        if (st.out_free) begin
          state_next = st.flushing ? ST_OFF_START : ST_IDLE;
        end
      end
      ST_SUMMARY: begin
        if (st.out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.take = in_valid;
      end
      ST_OFF_START: begin
        if (st.remain_ok) begin
          if (!st.skip_zero) begin
            cmd.skip_dec = 1'b1;
            cmd.advance  = 1'b1;
          end else begin
            cmd.pat_clear = 1'b1;
          end
        end
      end
      ST_RD: begin
        cmd = '0;
      end
      ST_CMP: begin
        if (!st.hit) begin
          if (st.last_pat) begin
            cmd.advance = 1'b1;
          end else begin
            cmd.pat_inc = 1'b1;
          end
        end
      end
      ST_MATCH: begin
        if (st.out_free) begin
          cmd.emit_match = 1'b1;
          cmd.advance    = 1'b1;
        end
      end
      ST_SUMMARY: begin
        cmd.emit_summary = st.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

@@ rtl/core/wms_dp.sv @@
// ----------------------------------------------------------------------------
// Wildcard multi-pattern scanner datapath
// Pattern lanes, byte window, offset counters, found set and the output
// register.
// ----------------------------------------------------------------------------
module wms_dp
  import wms_pkg::*;
#(
  parameter int NUM_PATTERNS = 4,
  parameter int MAX_LEN      = 16,
  parameter int OFFSET_BITS  = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  cmd_t        cmd,
  output status_t     st,
  input  logic        mode,
  input  logic [1:0]  pattern_index,
  input  logic [3:0]  byte_position,
  input  logic [7:0]  pattern_byte,
  input  logic [4:0]  pattern_length,
  input  logic [7:0]  data_byte,
  input  logic        end_of_region,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        report_kind,
  output logic [1:0]  found_pattern,
  output logic [31:0] match_offset,
  output logic [3:0]  found_mask,
  output logic        final_report
);

  localparam int PW = (NUM_PATTERNS > 1) ? $clog2(NUM_PATTERNS) : 1;
  localparam int LW = $clog2(MAX_LEN + 1);
  localparam int WW = $clog2(MAX_LEN);
  localparam int CW = (LW > 5) ? LW : 5;

  logic [LW-1:0]          lengths [NUM_PATTERNS];
  logic [NUM_PATTERNS-1:0] unfound;
  logic [NUM_PATTERNS-1:0] loaded;
  logic [7:0]             window [MAX_LEN];
  logic [7:0]             pat_row [MAX_LEN];
  logic [OFFSET_BITS-1:0] bytes_seen;
  logic [OFFSET_BITS-1:0] bytes_new;
  logic [OFFSET_BITS-1:0] n_cnt;
  logic [WW-1:0]          wptr;
  logic [WW-1:0]          rptr;
  logic [WW-1:0]          wptr_inc;
  logic [WW-1:0]          rptr_inc;
  logic [WW-1:0]          rptr_dec;
  logic [LW-1:0]          remain;
  logic [LW-1:0]          remain_init;
  logic [LW-1:0]          skip_cnt;
  logic [LW-1:0]          cur_len;
  logic [LW-1:0]          len_sat;
  logic [CW-1:0]          len_ext;
  logic [PW-1:0]          pcnt;
  logic [PW-1:0]          load_idx;
  logic                   flushing;
  logic                   sat;
  logic                   last_open;
  logic                   back_up;
  logic                   load_ok;
  logic                   scan_take;
  logic                   out_free;
  logic                   match;
  logic [MAX_LEN-1:0]     lane_ok;
  logic [WW:0]            pos [MAX_LEN];

  assign load_ok = cmd.take && (mode == MODE_LOAD) && (int'(pattern_index) < NUM_PATTERNS)
                   && (int'(byte_position) < MAX_LEN);
  assign scan_take = cmd.take && (mode == MODE_SCAN);
  assign load_idx  = PW'(pattern_index);
  assign len_ext   = CW'(pattern_length);
  assign len_sat   = (len_ext > CW'(MAX_LEN)) ? LW'(MAX_LEN) : LW'(pattern_length);

  // Once the byte count has saturated, the flush starts again at the last
  // decided offset unless that offset was skipped or matched.
  assign sat       = &bytes_seen;
  assign back_up   = scan_take && end_of_region && sat && last_open;
  assign bytes_new = sat ? bytes_seen : bytes_seen + 1'b1;
  assign wptr_inc  = (wptr == WW'(MAX_LEN - 1)) ? '0 : wptr + 1'b1;
  assign rptr_inc  = (rptr == WW'(MAX_LEN - 1)) ? '0 : rptr + 1'b1;
  assign rptr_dec  = (rptr == '0) ? WW'(MAX_LEN - 1) : rptr - 1'b1;
  assign remain_init = !end_of_region ? LW'(MAX_LEN) :
                       sat ? (last_open ? LW'(MAX_LEN) : LW'(MAX_LEN - 1)) :
                       (bytes_new >= OFFSET_BITS'(MAX_LEN)) ? LW'(MAX_LEN) : LW'(bytes_new);

  assign cur_len  = lengths[pcnt];
  assign out_free = !out_valid || out_ready;

  for (genvar k = 0; k < MAX_LEN; k++) begin : g_lane
    wms_ram #(
      .WIDTH(8),
      .DEPTH(NUM_PATTERNS)
    ) u_lane (
      .clk  (clk),
      .we   (load_ok && (int'(byte_position) == k)),
      .waddr(load_idx),
      .wdata(pattern_byte),
      .raddr(pcnt),
      .rdata(pat_row[k])
    );
  end

  always_comb begin
    for (int k = 0; k < MAX_LEN; k++) begin
      pos[k] = {1'b0, rptr} + (WW + 1)'(k);
      if (pos[k] >= (WW + 1)'(MAX_LEN)) begin
        pos[k] = pos[k] - (WW + 1)'(MAX_LEN);
      end
      lane_ok[k] = (LW'(k) >= cur_len) || (pat_row[k] == WILDCARD)
                   || (pat_row[k] == window[WW'(pos[k])]);
    end
    match = &lane_ok;
  end

  always_comb begin
    for (int p = 0; p < NUM_PATTERNS; p++) begin
      loaded[p] = (lengths[p] != '0);
    end
  end

  assign st.need_work = (mode == MODE_SCAN)
                        && (end_of_region || (!sat && bytes_seen >= OFFSET_BITS'(MAX_LEN - 1)));
  assign st.remain_ok = remain >= LW'(2);
  assign st.skip_zero = (skip_cnt == '0);
  assign st.hit       = unfound[pcnt] && (cur_len <= remain) && match;
  assign st.last_pat  = (pcnt == PW'(NUM_PATTERNS - 1));
  assign st.flushing  = flushing;
  assign st.out_free  = out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int p = 0; p < NUM_PATTERNS; p++) begin
        lengths[p] <= '0;
      end
      unfound    <= '0;
      bytes_seen <= '0;
      n_cnt      <= '0;
      wptr       <= '0;
      rptr       <= '0;
      skip_cnt   <= '0;
      pcnt       <= '0;
      flushing   <= 1'b0;
      last_open  <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (load_ok) begin
        lengths[load_idx] <= len_sat;
        unfound[load_idx] <= (len_sat != '0);
      end
      if (scan_take) begin
        if (!sat) begin
          bytes_seen <= bytes_new;
          wptr       <= wptr_inc;
        end
        flushing <= end_of_region;
      end
      if (back_up) begin
        n_cnt <= n_cnt - 1'b1;
        rptr  <= rptr_dec;
      end
      if (cmd.pat_clear) begin
        pcnt <= '0;
      end else if (cmd.pat_inc) begin
        pcnt <= pcnt + 1'b1;
      end
      if (cmd.emit_match) begin
        unfound[pcnt] <= 1'b0;
        skip_cnt      <= cur_len;
      end else if (cmd.skip_dec) begin
        skip_cnt <= skip_cnt - 1'b1;
      end
      if (cmd.advance) begin
        n_cnt     <= n_cnt + 1'b1;
        rptr      <= rptr_inc;
        last_open <= !cmd.skip_dec && !cmd.emit_match;
      end
      if (cmd.emit_summary) begin
        unfound    <= loaded;
        bytes_seen <= '0;
        n_cnt      <= '0;
        wptr       <= '0;
        rptr       <= '0;
        skip_cnt   <= '0;
        flushing   <= 1'b0;
      end
      if (cmd.emit_match || cmd.emit_summary) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (scan_take && !sat) begin
      window[wptr] <= data_byte;
    end
    if (scan_take) begin
      remain <= remain_init;
    end else if (cmd.advance) begin
      remain <= remain - 1'b1;
    end
    if (cmd.emit_match) begin
      report_kind   <= REPORT_FOUND;
      found_pattern <= 2'(pcnt);
      match_offset  <= 32'(n_cnt);
      found_mask    <= '0;
      final_report  <= 1'b0;
    end else if (cmd.emit_summary) begin
      report_kind   <= REPORT_SUMMARY;
      found_pattern <= '0;
      match_offset  <= '0;
      found_mask    <= 4'(loaded & ~unfound);
      final_report  <= 1'b1;
    end
  end

`ifndef SYNTHESIS
  a_emit_room: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit_match || cmd.emit_summary) |-> (!out_valid || out_ready))
    else $error("A word was written into a full output register.");

  a_match_unfound: assert property (@(posedge clk) disable iff (rst)
    cmd.emit_match |-> unfound[pcnt])
    else $error("A pattern already found was reported again.");

  a_match_retired: assert property (@(posedge clk) disable iff (rst)
    cmd.emit_match |=> !unfound[$past(pcnt)])
    else $error("A reported pattern was not retired.");

  a_summary_rearm: assert property (@(posedge clk) disable iff (rst)
    cmd.emit_summary |=> (!flushing && n_cnt == '0 && bytes_seen == '0))
    else $error("The summary did not return the scan state to its start.");
`endif

endmodule

@@ rtl/core/wildcard_multi_pattern_scanner_top.sv @@
// ----------------------------------------------------------------------------
// Wildcard multi-pattern scanner
// Loads wildcard byte signatures and scans a byte stream for them, reporting
// each first match with its offset and a summary at the end of a region.
// ----------------------------------------------------------------------------
//   Channel   Direction   Handshake              Word
//   in        input       in_valid / in_ready    one pattern byte or one data byte
//   out       output      out_valid / out_ready  one match report or one summary
//
// A load word and a scan word that decides no offset leave the sequencer idle.
// A scan word that decides an offset enters the offset start state: a skipped
// offset ends there, and otherwise each candidate pattern costs one pattern
// lane read and one window compare.
// The last word of a region adds one such decision per remaining offset, up to
// MAX_LEN-1 of them, then one end check and one summary report. Reset
// clears the lengths, the found set and the counters; the pattern lanes hold
// garbage until loaded.
// Results wait in the output register, and a full output register stalls the
// sequencer until out_ready.
module wildcard_multi_pattern_scanner_top
  import wms_pkg::*;
#(
  parameter int NUM_PATTERNS = 4,
  parameter int MAX_LEN      = 16,
  parameter int OFFSET_BITS  = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        mode,
  input  logic [1:0]  pattern_index,
  input  logic [3:0]  byte_position,
  input  logic [7:0]  pattern_byte,
  input  logic [4:0]  pattern_length,
  input  logic [7:0]  data_byte,
  input  logic        end_of_region,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        report_kind,
  output logic [1:0]  found_pattern,
  output logic [31:0] match_offset,
  output logic [3:0]  found_mask,
  output logic        final_report
);

  cmd_t    cmd;
  status_t st;

  wms_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .st      (st),
    .cmd     (cmd)
  );

  wms_dp #(
    .NUM_PATTERNS(NUM_PATTERNS),
    .MAX_LEN     (MAX_LEN),
    .OFFSET_BITS (OFFSET_BITS)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .st            (st),
    .mode          (mode),
    .pattern_index (pattern_index),
    .byte_position (byte_position),
    .pattern_byte  (pattern_byte),
    .pattern_length(pattern_length),
    .data_byte     (data_byte),
    .end_of_region (end_of_region),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .report_kind   (report_kind),
    .found_pattern (found_pattern),
    .match_offset  (match_offset),
    .found_mask    (found_mask),
    .final_report  (final_report)
  );

endmodule
